// File: design/mofq_pkg.sv
`timescale 1ns / 1ps

package mofq_pkg;

    // Item modes
    localparam logic [1:0] MODE_CHECK       = 2'd0;
    localparam logic [1:0] MODE_TICK        = 2'd1;
    localparam logic [1:0] MODE_CLEAR_FAULT = 2'd2;
    localparam logic [1:0] MODE_CLEAR_COUNT = 2'd3;

    // Trip event codes
    localparam logic [1:0] EVT_NONE    = 2'd0;
    localparam logic [1:0] EVT_TRIP    = 2'd1;
    localparam logic [1:0] EVT_LATCHED = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_CURRENT_LIMIT = 2'd0;
    localparam logic [1:0] CFG_NOISE_TIME    = 2'd1;
    localparam logic [1:0] CFG_REPEAT_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_WINDOW_TIME   = 2'd3;

    // Configuration reset values
    localparam logic [15:0] RST_CURRENT_LIMIT = 16'd65535;
    localparam logic [15:0] RST_NOISE_TIME    = 16'd100;
    localparam logic [7:0]  RST_REPEAT_LIMIT  = 8'd3;
    localparam logic [15:0] RST_WINDOW_TIME   = 16'd1000;

    localparam logic [7:0] TRIP_COUNT_MAX = 8'd255;

    // One input item
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] current_ma;
        logic        motion_idle;
    } item_t;

    // Qualifier state
    typedef struct packed {
        logic        fault_latched;
        logic [15:0] noise_remaining;
        logic        noise_active;
        logic        noise_expired;
        logic [7:0]  trips_counted;
        logic [15:0] window_remaining;
        logic        window_expired;
    } qual_state_t;

endpackage

// File: design/motor_overcurrent_fault_qualifier_core.sv
`timescale 1ns / 1ps
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle while m_ready takes results; the input register lets an
// item be taken while a result waits on m_ready, and the whole qualifier update is one
// pass of compare and count logic.
// Reset: synchronous, active-low aresetn clears all qualifier state and both valid flags and
// loads the configuration registers with their default values.
module motor_overcurrent_fault_qualifier_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [15:0] s_current_ma,
    input  logic        s_motion_idle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_fault,
    output logic [1:0]  m_trip_event,
    output logic [7:0]  m_trip_count
);
    import mofq_pkg::*;

    logic [15:0] current_limit_reg;
    logic [15:0] noise_time_reg;
    logic [7:0]  repeat_limit_reg;
    logic [15:0] window_time_reg;

    item_t       item_reg;
    logic        item_valid_reg;
    qual_state_t state_reg;
    qual_state_t state_next;
    logic [1:0]  event_next;
    logic        out_valid_reg;
    logic        fault_reg;
    logic [1:0]  event_reg;
    logic [7:0]  count_reg;
    logic        advance;

    // Move the held item into the result register when that register is free
    assign advance = item_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_limit_reg <= RST_CURRENT_LIMIT;
            noise_time_reg    <= RST_NOISE_TIME;
            repeat_limit_reg  <= RST_REPEAT_LIMIT;
            window_time_reg   <= RST_WINDOW_TIME;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CURRENT_LIMIT: current_limit_reg <= cfg_wdata;
                CFG_NOISE_TIME:    noise_time_reg    <= cfg_wdata;
                CFG_REPEAT_LIMIT:  repeat_limit_reg  <= cfg_wdata[7:0];
                CFG_WINDOW_TIME:   window_time_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.mode        <= s_mode;
            item_reg.current_ma  <= s_current_ma;
            item_reg.motion_idle <= s_motion_idle;
        end
    end

    // Qualifier update for the held item
    always_comb begin
        state_next = state_reg;
        event_next = EVT_NONE;
        case (item_reg.mode)
            MODE_CHECK: begin
                if (item_reg.motion_idle) begin
                    if (item_reg.current_ma >= current_limit_reg) begin
                        if (!state_reg.fault_latched) begin
                            if (!state_reg.noise_active) begin
                                // start the noise filter
                                if (noise_time_reg == 16'd0) begin
                                    state_next.noise_expired   = 1'b1;
                                    state_next.noise_remaining = 16'd0;
                                end else begin
                                    state_next.noise_remaining = noise_time_reg;
                                    state_next.noise_active    = 1'b1;
                                    state_next.noise_expired   = 1'b0;
                                end
                            end else if (state_reg.noise_expired) begin
                                // count the trip
                                state_next.noise_remaining = 16'd0;
                                state_next.noise_active    = 1'b0;
                                if (state_reg.trips_counted != TRIP_COUNT_MAX) begin
                                    state_next.trips_counted = state_reg.trips_counted + 8'd1;
                                end
                                if (state_next.trips_counted >= repeat_limit_reg) begin
                                    state_next.fault_latched    = 1'b1;
                                    state_next.trips_counted    = 8'd0;
                                    state_next.window_remaining = 16'd0;
                                    event_next                  = EVT_LATCHED;
                                end else begin
                                    if (window_time_reg == 16'd0) begin
                                        state_next.window_expired   = 1'b1;
                                        state_next.window_remaining = 16'd0;
                                    end else begin
                                        state_next.window_remaining = window_time_reg;
                                        state_next.window_expired   = 1'b0;
                                    end
                                    event_next = EVT_TRIP;
                                end
                            end
                        end
                    end else begin
                        // drop the noise filter on a low sample
                        state_next.noise_remaining = 16'd0;
                        state_next.noise_active    = 1'b0;
                    end
                    // window over: clear the count
                    if (state_next.window_expired) begin
                        state_next.noise_remaining  = 16'd0;
                        state_next.trips_counted    = 8'd0;
                        state_next.noise_active     = 1'b0;
                        state_next.window_remaining = 16'd0;
                        state_next.window_expired   = 1'b0;
                    end
                end
            end
            MODE_TICK: begin
                if (state_reg.noise_remaining != 16'd0) begin
                    state_next.noise_remaining = state_reg.noise_remaining - 16'd1;
                    state_next.noise_expired   = (state_reg.noise_remaining == 16'd1);
                end
                if (state_reg.window_remaining != 16'd0) begin
                    state_next.window_remaining = state_reg.window_remaining - 16'd1;
                    state_next.window_expired   = (state_reg.window_remaining == 16'd1);
                end
            end
            MODE_CLEAR_FAULT: begin
                state_next.fault_latched = 1'b0;
            end
            MODE_CLEAR_COUNT: begin
                state_next.noise_remaining  = 16'd0;
                state_next.trips_counted    = 8'd0;
                state_next.noise_active     = 1'b0;
                state_next.window_remaining = 16'd0;
                state_next.window_expired   = 1'b0;
            end
            default: ;
        endcase
    end

    // Qualifier state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            fault_reg <= state_next.fault_latched;
            event_reg <= event_next;
            count_reg <= state_next.trips_counted;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_fault      = fault_reg;
    assign m_trip_event = event_reg;
    assign m_trip_count = count_reg;

endmodule

// File: design/mofq_checker.sv
`timescale 1ns / 1ps
module mofq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_fault,
    input logic [1:0]  m_trip_event,
    input logic [7:0]  m_trip_count
);
    import mofq_pkg::*;

    // No result right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Only defined event codes
    a_event_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_trip_event == EVT_NONE || m_trip_event == EVT_TRIP ||
                     m_trip_event == EVT_LATCHED))
        else $error("undefined trip event code");

    // A latch event shows the fault set and the count cleared
    a_latch_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_trip_event == EVT_LATCHED) |-> (m_fault && m_trip_count == 8'd0))
        else $error("latch event without fault set and count cleared");

    // A counted trip happens only while no fault is latched
    a_trip_no_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_trip_event == EVT_TRIP) |-> !m_fault)
        else $error("trip counted while fault latched");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_fault) &&
                                   $stable(m_trip_event) && $stable(m_trip_count)))
        else $error("stalled result changed");

endmodule

bind motor_overcurrent_fault_qualifier_core mofq_checker u_mofq_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_fault      (m_fault),
    .m_trip_event (m_trip_event),
    .m_trip_count (m_trip_count)
);
